@@ hw/rtl/chgsup_pkg.sv @@
`timescale 1ns / 1ps
package chgsup_pkg;

  localparam int AdcBits = 12;
  localparam int RefNum  = 1200 * (1 << AdcBits);
  localparam int NumW    = $clog2(RefNum + 1);

  typedef enum logic [2:0] {
    MODE_INIT     = 3'd0,
    MODE_START    = 3'd1,
    MODE_CHARGING = 3'd2,
    MODE_STOP     = 3'd3,
    MODE_OVER     = 3'd4,
    MODE_SLEEP    = 3'd5
  } mode_e;

  localparam logic [2:0] LedNone  = 3'd0;
  localparam logic [2:0] LedSlow  = 3'd1;
  localparam logic [2:0] LedShort = 3'd2;
  localparam logic [2:0] LedFast  = 3'd3;
  localparam logic [2:0] LedOff   = 3'd4;

  localparam logic [2:0] RegMinIn   = 3'd0;
  localparam logic [2:0] RegMaxIn   = 3'd1;
  localparam logic [2:0] RegMinCur  = 3'd2;
  localparam logic [2:0] RegSleepIn = 3'd3;
  localparam logic [2:0] RegCutoff  = 3'd4;
  localparam logic [2:0] RegTarget  = 3'd5;
  localparam logic [2:0] RegPotLim  = 3'd6;
  localparam logic [2:0] RegSettle  = 3'd7;

  localparam logic [7:0] FrameStart = 8'h02;
  localparam logic [7:0] FrameLen   = 8'd12;

  // Raw samples queued between the front and back parts.
  typedef struct packed {
    logic [AdcBits-1:0] ch_in;
    logic [AdcBits-1:0] ch_cur;
    logic [AdcBits-1:0] ch_out;
    logic [AdcBits-1:0] ch_ref;
    logic               due;
  } sample_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [15:0] min_in;
    logic [15:0] max_in;
    logic [15:0] min_cur;
    logic [15:0] sleep_in;
    logic [15:0] cutoff;
    logic [15:0] target;
    logic [7:0]  pot_lim;
    logic [15:0] settle;
  } cfg_t;

  function automatic logic [15:0] sat16(logic [47:0] v);
    return (v > 48'd65535) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

@@ hw/rtl/chgsup_front.sv @@
`timescale 1ns / 1ps
module chgsup_front import chgsup_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [AdcBits-1:0] adc_input_raw_i,
  input  logic [AdcBits-1:0] adc_current_raw_i,
  input  logic [AdcBits-1:0] adc_output_raw_i,
  input  logic [AdcBits-1:0] adc_reference_raw_i,
  input  logic               report_due_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output sample_t            q_data_o
);

  // Two-entry queue that decouples the input channel from the back part.
  sample_t     mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rd_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{ch_in: adc_input_raw_i, ch_cur: adc_current_raw_i,
                       ch_out: adc_output_raw_i, ch_ref: adc_reference_raw_i,
                       due: report_due_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ hw/rtl/chgsup_div.sv @@
`timescale 1ns / 1ps
module chgsup_div import chgsup_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [NumW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  // Restoring divider, one quotient bit per cycle. The done flag is
  // registered, so the quotient is complete in the cycle it is raised.
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] rem_q, quo_q, den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [NumW:0]   trial;

  assign trial  = {rem_q, quo_q[NumW-1]} - {1'b0, den_q};
  assign quo_o  = quo_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(NumW);
      rem_q  <= '0;
      quo_q  <= num_i;
      den_q  <= den_i;
    end else if (busy_q) begin
      if (!trial[NumW]) begin
        rem_q <= trial[NumW-1:0];
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[NumW-2:0], quo_q[NumW-1]};
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
      cnt_q  <= cnt_q - CntW'(1);
      done_q <= (cnt_q == CntW'(1));
      if (cnt_q == CntW'(1)) busy_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/chgsup_back.sv @@
`timescale 1ns / 1ps
module chgsup_back import chgsup_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  sample_t     q_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [2:0]  mode_code_o,
  output logic        buck_enable_o,
  output logic        pot_write_o,
  output logic [7:0]  pot_value_o,
  output logic [2:0]  led_pattern_o,
  output logic        stop_mode_request_o,
  output logic [7:0]  frame_byte_o,
  output logic        last_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUP, ST_SUPW, ST_MUL1, ST_MUL2, ST_RECIP, ST_NEXT, ST_MODE,
    ST_CTRL, ST_FRAME
  } state_e;

  // Constant divisions use reciprocal multiplication: for x below 2^22,
  // floor(x / d) equals (x * m) >> 28 with m rounded up from 2^28 / d.
  localparam int RecipShift = 28;
  localparam int RecipW     = 22;

  state_e                 st_q;
  sample_t                smp_q;
  logic [1:0]             ch_q;        // 0 input, 1 output, 2 current
  logic [15:0]            sup_q, vin_q, vout_q, cur_q;
  logic [AdcBits+15:0]    prod_q;
  logic [27:0]            gain_q;
  logic [46:0]            recip_q;
  logic                   sat_q;
  logic [6:0]             rdiff_q;
  logic [2:0]             mode_q;
  logic [7:0]             regv_q, pot_q;
  logic [2:0]             rdiv_q;
  logic [15:0]            cnt_q;
  logic                   buck_q;
  logic [3:0]             fidx_q;
  logic [7:0]             xor_q;

  logic            dstart;
  logic [NumW-1:0] dnum, dden, dquo;
  logic            ddone;

  chgsup_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
    .done_o(ddone), .quo_o(dquo)
  );

  // Channel selection and reduced gain ratios (2247/47, 71/15, 50/39).
  logic [AdcBits-1:0] raw_sel;
  logic [11:0]        gnum;
  logic [27:0]        glim;
  logic [24:0]        gmag;
  always_comb begin
    case (ch_q)
      2'd0: begin
        raw_sel = smp_q.ch_in;  gnum = 12'd2247;
        glim = 28'd3080192;     gmag = 25'd5711393;
      end
      2'd1: begin
        raw_sel = smp_q.ch_out; gnum = 12'd71;
        glim = 28'd983040;      gmag = 25'd17895698;
      end
      default: begin
        raw_sel = smp_q.ch_cur; gnum = 12'd50;
        glim = 28'd2555904;     gmag = 25'd6882961;
      end
    endcase
  end

  // The divider only computes the supply from the reference sample.
  assign dstart = (st_q == ST_SUP) && (smp_q.ch_ref != '0);
  assign dnum   = NumW'(RefNum);
  assign dden   = {{(NumW-AdcBits){1'b0}}, smp_q.ch_ref};

  // Regulator step size: (target - input) / 1000 by reciprocal multiplication.
  logic [15:0] rgap;
  logic [32:0] rprod;
  assign rgap  = cfg_i.target - vin_q;
  assign rprod = {17'd0, rgap} * 33'd67109;

  // Regulator next value.
  logic [9:0]  rsum;
  logic [7:0]  rnext;
  always_comb begin
    if (vin_q > cfg_i.target) rsum = {2'b0, regv_q} - 10'd1;
    else                     rsum = {2'b0, regv_q} + {3'b0, rdiff_q};
    if (vin_q > cfg_i.target && regv_q == 8'd0) rnext = 8'd0;
    else if (rsum > {2'b0, cfg_i.pot_lim})      rnext = cfg_i.pot_lim;
    else                                        rnext = rsum[7:0];
  end

  // Frame byte selection.
  logic [7:0] fbyte;
  always_comb begin
    case (fidx_q)
      4'd0:    fbyte = FrameStart;
      4'd1:    fbyte = FrameLen;
      4'd2:    fbyte = vin_q[15:8];
      4'd3:    fbyte = vin_q[7:0];
      4'd4:    fbyte = vout_q[15:8];
      4'd5:    fbyte = vout_q[7:0];
      4'd6:    fbyte = cur_q[15:8];
      4'd7:    fbyte = cur_q[7:0];
      4'd8:    fbyte = sup_q[15:8];
      4'd9:    fbyte = sup_q[7:0];
      4'd10:   fbyte = pot_q;
      default: fbyte = xor_q;
    endcase
  end

  assign q_ready_o = (st_q == ST_IDLE);

  // Sequencer: scale, run the mode machine, then emit results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [2:0] m;
    logic       w;
    logic [2:0] l;
    logic       s;
    logic [15:0] scaled;
    if (!rst_ni) begin
      st_q <= ST_IDLE; smp_q <= '0; ch_q <= '0; sup_q <= '0; vin_q <= '0;
      vout_q <= '0; cur_q <= '0; prod_q <= '0; gain_q <= '0;
      recip_q <= '0; sat_q <= 1'b0; rdiff_q <= '0;
      mode_q <= MODE_INIT; regv_q <= 8'd30; pot_q <= '0; rdiv_q <= '0;
      cnt_q <= '0; buck_q <= 1'b0; fidx_q <= '0; xor_q <= '0;
      out_valid_o <= 1'b0; result_kind_o <= 1'b0; mode_code_o <= '0;
      buck_enable_o <= 1'b0; pot_write_o <= 1'b0; pot_value_o <= '0;
      led_pattern_o <= '0; stop_mode_request_o <= 1'b0; frame_byte_o <= '0;
      last_o <= 1'b0;
    end else begin
      unique case (st_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            smp_q <= q_data_i;
            st_q  <= ST_SUP;
          end
        end
        ST_SUP: begin
          ch_q <= 2'd0;
          if (smp_q.ch_ref == '0) begin
            sup_q <= 16'hFFFF;
            st_q  <= ST_MUL1;
          end else begin
            st_q <= ST_SUPW;
          end
        end
        ST_SUPW: begin
          if (ddone) begin
            sup_q <= sat16({{(48-NumW){1'b0}}, dquo});
            st_q  <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          prod_q <= {16'd0, raw_sel} * {{AdcBits{1'b0}}, sup_q};
          st_q   <= ST_MUL2;
        end
        ST_MUL2: begin
          gain_q <= {12'd0, prod_q[AdcBits +: 16]} * {16'd0, gnum};
          st_q   <= ST_RECIP;
        end
        ST_RECIP: begin
          // Anything at or above 65536 times the divisor saturates.
          sat_q   <= (gain_q >= glim);
          recip_q <= {25'd0, gain_q[RecipW-1:0]} * {22'd0, gmag};
          st_q    <= ST_NEXT;
        end
        ST_NEXT: begin
          scaled = sat_q ? 16'hFFFF : recip_q[RecipShift +: 16];
          case (ch_q)
            2'd0:    vin_q  <= scaled;
            2'd1:    vout_q <= scaled;
            default: cur_q  <= scaled;
          endcase
          if (ch_q == 2'd2) begin
            rdiff_q <= rprod[32:26];
            st_q    <= ST_MODE;
          end else begin
            ch_q <= ch_q + 2'd1;
            st_q <= ST_MUL1;
          end
        end
        ST_MODE: begin
          m = mode_q; w = 1'b0; l = LedNone; s = 1'b0;
          if (vin_q > cfg_i.max_in)   m = MODE_OVER;
          if (vin_q < cfg_i.sleep_in) m = MODE_SLEEP;
          case (m)
            MODE_INIT: begin
              buck_q <= 1'b0; pot_q <= cfg_i.pot_lim; regv_q <= cfg_i.pot_lim;
              if (vin_q < cfg_i.max_in && vin_q > cfg_i.min_in) m = MODE_START;
              else l = LedSlow;
            end
            MODE_START: begin
              buck_q <= 1'b1; m = MODE_CHARGING;
            end
            MODE_CHARGING: begin
              l = LedShort; w = 1'b1;
              if (rdiv_q == 3'd5) begin
                regv_q <= rnext; pot_q <= rnext; rdiv_q <= 3'd1;
              end else begin
                rdiv_q <= rdiv_q + 3'd1;
              end
              if (vin_q < cfg_i.min_in) m = MODE_INIT;
              else if (cur_q < cfg_i.min_cur && cnt_q > cfg_i.settle &&
                       sup_q > cfg_i.cutoff) begin
                cnt_q <= 16'd1; m = MODE_STOP;
              end else cnt_q <= cnt_q + 16'd1;
            end
            MODE_STOP: begin
              buck_q <= 1'b0; pot_q <= cfg_i.pot_lim; regv_q <= cfg_i.pot_lim;
              m = MODE_SLEEP;
            end
            MODE_OVER: begin
              l = LedFast; buck_q <= 1'b0;
              if (vin_q < cfg_i.max_in) m = MODE_INIT;
            end
            default: begin
              if (m == MODE_SLEEP) begin
                l = LedOff; s = 1'b1;
              end
              m = MODE_INIT;
            end
          endcase
          mode_q <= m;
          led_pattern_o <= l; stop_mode_request_o <= s; pot_write_o <= w;
          mode_code_o <= m;
          st_q <= ST_CTRL;
        end
        ST_CTRL: begin
          // Register values updated in ST_MODE are visible here.
          result_kind_o <= 1'b0;
          buck_enable_o <= buck_q;
          pot_value_o   <= pot_write_o ? pot_q : 8'd0;
          frame_byte_o  <= 8'd0;
          last_o        <= ~smp_q.due;
          out_valid_o   <= 1'b1;
          fidx_q        <= '0;
          xor_q         <= '0;
          st_q          <= ST_FRAME;
        end
        default: begin
          // ST_FRAME: wait for the current transaction, then load the next byte or return to idle.
          if (out_ready_i || !out_valid_o) begin
            if (!smp_q.due || fidx_q == 4'd12) begin
              out_valid_o <= 1'b0;
              st_q        <= ST_IDLE;
            end else begin
              result_kind_o <= 1'b1; mode_code_o <= '0; buck_enable_o <= 1'b0;
              pot_write_o <= 1'b0; pot_value_o <= '0; led_pattern_o <= '0;
              stop_mode_request_o <= 1'b0;
              frame_byte_o <= fbyte;
              last_o       <= (fidx_q == 4'd11);
              out_valid_o  <= 1'b1;
              xor_q        <= xor_q ^ fbyte;
              fidx_q       <= fidx_q + 4'd1;
            end
          end
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/charger_supervisor.sv @@
`timescale 1ns / 1ps
// Charger supervisor.
// Input channel (in_valid_i/in_ready_o) carries one set of raw converter
// samples plus a report flag per transaction. A two-entry queue holds them
// while the back part scales the channels, runs the charger mode machine and
// emits results on the output channel (out_valid_o/out_ready_i).
// Each input gives one control result, followed by 12 status frame bytes
// when report_due_i is set; last_o marks the final result of an input.
// The control result follows the input transaction once the back part has
// taken the item from the queue, started and waited on the serial supply
// divider, run the scaling multiplies for each channel, and done the mode
// step and the control result. A zero reference skips the divider. The
// back part takes a new item only once every result of the previous item,
// status frame bytes included, has been taken.
// A stalled receiver holds the current result and the back part waits; the
// queue keeps accepting until full. Configuration writes (cfg_valid_i/
// cfg_ready_o) are always taken. Reset restores the default register values
// and init mode; no clearing pass is needed.
module charger_supervisor import chgsup_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [AdcBits-1:0] adc_input_raw_i,
  input  logic [AdcBits-1:0] adc_current_raw_i,
  input  logic [AdcBits-1:0] adc_output_raw_i,
  input  logic [AdcBits-1:0] adc_reference_raw_i,
  input  logic               report_due_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               result_kind_o,
  output logic [2:0]         mode_code_o,
  output logic               buck_enable_o,
  output logic               pot_write_o,
  output logic [7:0]         pot_value_o,
  output logic [2:0]         led_pattern_o,
  output logic               stop_mode_request_o,
  output logic [7:0]         frame_byte_o,
  output logic               last_o
);

  cfg_t    cfg_q;
  logic    q_valid, q_ready;
  sample_t q_data;

  assign cfg_ready_o = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{min_in: 16'd5000, max_in: 16'd22000, min_cur: 16'd200,
                 sleep_in: 16'd1000, cutoff: 16'd2600, target: 16'd10000,
                 pot_lim: 8'd30, settle: 16'd100};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMinIn:   cfg_q.min_in   <= cfg_data_i;
        RegMaxIn:   cfg_q.max_in   <= cfg_data_i;
        RegMinCur:  cfg_q.min_cur  <= cfg_data_i;
        RegSleepIn: cfg_q.sleep_in <= cfg_data_i;
        RegCutoff:  cfg_q.cutoff   <= cfg_data_i;
        RegTarget:  cfg_q.target   <= cfg_data_i;
        RegPotLim:  cfg_q.pot_lim  <= cfg_data_i[7:0];
        default:    cfg_q.settle   <= cfg_data_i;
      endcase
    end
  end

  chgsup_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .adc_input_raw_i, .adc_current_raw_i, .adc_output_raw_i,
    .adc_reference_raw_i, .report_due_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  chgsup_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid_o, .out_ready_i, .result_kind_o, .mode_code_o, .buck_enable_o,
    .pot_write_o, .pot_value_o, .led_pattern_o, .stop_mode_request_o,
    .frame_byte_o, .last_o
  );

endmodule
